[sv/owm_pkg.sv]
// ---------------------------------------------------------------------------
// owm_pkg: shared types and constants for the one-wire bus master
// Item structs, command codes, reset status codes, timing register indexes
// and their reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

  localparam int TIMER_WIDTH_DEFAULT = 10;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 3;

  // command codes
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_RESET      = 3'd1;
  localparam logic [2:0] OP_WRITE_BIT  = 3'd2;
  localparam logic [2:0] OP_READ_BIT   = 3'd3;
  localparam logic [2:0] OP_WRITE_BYTE = 3'd4;
  localparam logic [2:0] OP_READ_BYTE  = 3'd5;

  // reset status codes
  localparam logic [1:0] ST_PRESENT = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_SHORTED = 2'd2;

  // timing register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_SAMP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd7;

  // timing register reset values, in ticks
  localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd485;
  localparam logic [CFG_W-1:0] RST_PRESENCE_SAMP = 10'd68;
  localparam logic [CFG_W-1:0] RST_RESET_TAIL    = 10'd417;
  localparam logic [CFG_W-1:0] RST_ONE_LOW       = 10'd8;
  localparam logic [CFG_W-1:0] RST_ZERO_LOW      = 10'd64;
  localparam logic [CFG_W-1:0] RST_SLOT          = 10'd75;
  localparam logic [CFG_W-1:0] RST_READ_LOW      = 10'd5;
  localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd11;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       line_level;
  } owm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic [1:0] reset_status;
  } owm_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low_time;
    logic [CFG_W-1:0] presence_sample_time;
    logic [CFG_W-1:0] reset_tail_time;
    logic [CFG_W-1:0] one_low_time;
    logic [CFG_W-1:0] zero_low_time;
    logic [CFG_W-1:0] slot_time;
    logic [CFG_W-1:0] read_low_time;
    logic [CFG_W-1:0] read_sample_time;
  } owm_cfg_t;

endpackage

`default_nettype wire

[sv/owm_cfg.sv]
// ---------------------------------------------------------------------------
// owm_cfg: timing register file
// Eight 10-bit tick counts, loaded with their defaults at reset and written
// one at a time through the configuration channel.
// ---------------------------------------------------------------------------
`default_nettype none

module owm_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [owm_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [owm_pkg::CFG_W-1:0]       wr_data,
  output owm_pkg::owm_cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_time       <= owm_pkg::RST_RESET_LOW;
      cfg.presence_sample_time <= owm_pkg::RST_PRESENCE_SAMP;
      cfg.reset_tail_time      <= owm_pkg::RST_RESET_TAIL;
      cfg.one_low_time         <= owm_pkg::RST_ONE_LOW;
      cfg.zero_low_time        <= owm_pkg::RST_ZERO_LOW;
      cfg.slot_time            <= owm_pkg::RST_SLOT;
      cfg.read_low_time        <= owm_pkg::RST_READ_LOW;
      cfg.read_sample_time     <= owm_pkg::RST_READ_SAMPLE;
    end else if (wr_en) begin
      case (wr_index)
        owm_pkg::REG_RESET_LOW:     cfg.reset_low_time       <= wr_data;
        owm_pkg::REG_PRESENCE_SAMP: cfg.presence_sample_time <= wr_data;
        owm_pkg::REG_RESET_TAIL:    cfg.reset_tail_time      <= wr_data;
        owm_pkg::REG_ONE_LOW:       cfg.one_low_time         <= wr_data;
        owm_pkg::REG_ZERO_LOW:      cfg.zero_low_time        <= wr_data;
        owm_pkg::REG_SLOT:          cfg.slot_time            <= wr_data;
        owm_pkg::REG_READ_LOW:      cfg.read_low_time        <= wr_data;
        owm_pkg::REG_READ_SAMPLE:   cfg.read_sample_time     <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/owm_core.sv]
// ---------------------------------------------------------------------------
// owm_core: bus sequencer
// Phase register, tick counter, bit counter and shift byte. Each accepted
// item advances the sequence by one tick and yields that tick's result.
// ---------------------------------------------------------------------------
`default_nettype none

module owm_core #(
  parameter int TimerWidth = owm_pkg::TIMER_WIDTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire owm_pkg::owm_in_t  item,
  input  wire owm_pkg::owm_cfg_t cfg,
  output owm_pkg::owm_out_t      res_next
);

  localparam int LW = ((TimerWidth > owm_pkg::CFG_W) ? TimerWidth : owm_pkg::CFG_W) + 1;
  localparam logic [LW-1:0] TOP = {{(LW-1){1'b0}}, 1'b1} << TimerWidth;
  localparam logic [LW-1:0] ONE = {{(LW-1){1'b0}}, 1'b1};
  localparam logic [LW-1:0] TWO = {{(LW-2){1'b0}}, 2'b10};

  typedef enum logic [2:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_TAIL, PH_SLOT
  } phase_t;

  phase_t                phase, phase_next;
  logic [TimerWidth-1:0] tick_count, tick_count_next;
  logic [3:0]            bit_index, bit_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic                  first_sample, first_sample_next;
  logic [1:0]            status_reg, status_reg_next;
  logic [2:0]            command_kind, command_kind_next;
  logic [7:0]            last_read, last_read_next;

  // clamp a time to [mn, 2^TimerWidth]
  function automatic logic [LW-1:0] lim(input logic [owm_pkg::CFG_W-1:0] v,
                                        input logic [LW-1:0] mn);
    logic [LW-1:0] x;
    x = LW'(v);
    if (x < mn) x = mn;
    if (x > TOP) x = TOP;
    return x;
  endfunction

  logic [LW-1:0] tc_ext, tc_inc, slot, slot_m1, spos, low_time;
  logic          is_read, single, phase_done, drive, busy, done;

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_index_next    = bit_index;
    shift_byte_next   = shift_byte;
    first_sample_next = first_sample;
    status_reg_next   = status_reg;
    command_kind_next = command_kind;
    last_read_next    = last_read;
    drive             = 1'b0;
    done              = 1'b0;
    phase_done        = 1'b0;
    spos              = '0;
    low_time          = '0;

    // start a command on the tick it arrives
    if (phase == PH_IDLE && item.op inside {owm_pkg::OP_RESET, owm_pkg::OP_WRITE_BIT,
        owm_pkg::OP_READ_BIT, owm_pkg::OP_WRITE_BYTE, owm_pkg::OP_READ_BYTE}) begin
      command_kind_next = item.op;
      tick_count_next   = '0;
      bit_index_next    = '0;
      if (item.op == owm_pkg::OP_RESET) begin
        phase_next      = PH_RST_LOW;
        shift_byte_next = '0;
      end else begin
        phase_next = PH_SLOT;
        case (item.op)
          owm_pkg::OP_WRITE_BIT:  shift_byte_next = {7'd0, item.data[0]};
          owm_pkg::OP_WRITE_BYTE: shift_byte_next = item.data;
          default:                shift_byte_next = '0;
        endcase
      end
    end

    busy    = (phase_next != PH_IDLE);
    tc_ext  = LW'(tick_count_next);
    tc_inc  = tc_ext + ONE;
    slot    = lim(cfg.slot_time, TWO);
    slot_m1 = slot - ONE;
    is_read = (command_kind_next == owm_pkg::OP_READ_BIT) ||
              (command_kind_next == owm_pkg::OP_READ_BYTE);
    single  = (command_kind_next == owm_pkg::OP_WRITE_BIT) ||
              (command_kind_next == owm_pkg::OP_READ_BIT);

    case (phase_next)
      PH_RST_LOW: begin
        drive      = 1'b1;
        phase_done = (tc_inc >= lim(cfg.reset_low_time, ONE));
        if (phase_done) begin
          phase_next      = PH_RST_WAIT;
          tick_count_next = '0;
        end else begin
          tick_count_next = tc_inc[TimerWidth-1:0];
        end
      end
      PH_RST_WAIT: begin
        phase_done = (tc_inc >= lim(cfg.presence_sample_time, ONE));
        if (phase_done) begin
          first_sample_next = item.line_level;
          phase_next        = PH_RST_TAIL;
          tick_count_next   = '0;
        end else begin
          tick_count_next = tc_inc[TimerWidth-1:0];
        end
      end
      PH_RST_TAIL: begin
        phase_done = (tc_inc >= lim(cfg.reset_tail_time, ONE));
        if (phase_done) begin
          if (first_sample) status_reg_next = owm_pkg::ST_NONE;
          else if (item.line_level) status_reg_next = owm_pkg::ST_PRESENT;
          else status_reg_next = owm_pkg::ST_SHORTED;
          done            = 1'b1;
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end else begin
          tick_count_next = tc_inc[TimerWidth-1:0];
        end
      end
      PH_SLOT: begin
        if (is_read) begin
          spos = LW'(cfg.read_sample_time);
          if (spos > slot_m1) spos = slot_m1;
          drive = (tc_ext < LW'(cfg.read_low_time)) || (tc_ext == '0);
          if (tc_ext == spos) shift_byte_next = {item.line_level, shift_byte_next[7:1]};
        end else begin
          low_time = shift_byte_next[0] ? LW'(cfg.one_low_time) : LW'(cfg.zero_low_time);
          drive    = (tc_ext < low_time) || (tc_ext == '0);
        end
        phase_done = (tc_inc >= slot);
        if (phase_done) begin
          tick_count_next = '0;
          if (!is_read) shift_byte_next = {1'b0, shift_byte_next[7:1]};
          bit_index_next = bit_index_next + 4'd1;
          if (bit_index_next >= (single ? 4'd1 : 4'd8)) begin
            if (is_read) last_read_next = single ? {7'd0, shift_byte_next[7]} : shift_byte_next;
            done       = 1'b1;
            phase_next = PH_IDLE;
          end
        end else begin
          tick_count_next = tc_inc[TimerWidth-1:0];
        end
      end
      default: ;
    endcase

    res_next.drive_low    = drive;
    res_next.busy_res     = busy;
    res_next.done_res     = done;
    res_next.read_value   = last_read_next;
    res_next.reset_status = status_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      bit_index    <= '0;
      shift_byte   <= '0;
      first_sample <= 1'b0;
      status_reg   <= '0;
      command_kind <= '0;
      last_read    <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      bit_index    <= bit_index_next;
      shift_byte   <= shift_byte_next;
      first_sample <= first_sample_next;
      status_reg   <= status_reg_next;
      command_kind <= command_kind_next;
      last_read    <= last_read_next;
    end
  end

endmodule

`default_nettype wire

[sv/one_wire_bus_master_top.sv]
// ---------------------------------------------------------------------------
// one_wire_bus_master_top: one-wire bus master, one item per bus tick
// Sequences reset/presence, bit and byte slots from 1 us tick items.
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one item per 1 us tick: command, write byte and
//   the sampled line level. Commands are taken only while idle; otherwise
//   the command field is ignored and the item just advances the sequence.
//   out_valid/out_ready return one result per item: line drive, busy, done,
//   last read value and last reset status.
//   The result of an item is in the output register on the cycle after it
//   is accepted. Throughput is one item per cycle while the receiver takes
//   results, set by the single sequencer state update per item.
//   A new item is taken while the output register is empty or being
//   drained; when the receiver stalls, the result holds and input stalls.
//   cfg_valid/cfg_index/cfg_data write the eight timing registers; the port
//   is always ready. Only write while the master is idle (not enforced).
//   Reset returns the sequencer to idle, clears status and read value, and
//   loads the default timing registers.
// ---------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master_top #(
  parameter int TimerWidth = owm_pkg::TIMER_WIDTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output wire logic                           in_ready,
  input  wire owm_pkg::owm_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output owm_pkg::owm_out_t                   out_data,
  input  wire logic                           cfg_valid,
  output wire logic                           cfg_ready,
  input  wire logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [owm_pkg::CFG_W-1:0]      cfg_data
);

  owm_pkg::owm_cfg_t cfg;
  owm_pkg::owm_out_t res_next;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  owm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  owm_core #(
    .TimerWidth (TimerWidth)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .advance  (accept),
    .item     (in_data),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // output register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_drive_needs_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.drive_low |-> out_data.busy_res)
    else $error("line driven low outside a command");

  a_done_needs_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> out_data.busy_res)
    else $error("done reported outside a command");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.reset_status != 2'd3)
    else $error("undefined reset status code");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item left no result");
`endif

endmodule

`default_nettype wire

[verif/one_wire_bus_master_top_tb.sv]
// ---------------------------------------------------------------------------
// one_wire_bus_master_top_tb: self-checking bench for the one-wire bus master
// Drives tick items (command, write byte, sampled line level) through the
// valid/ready input, rewrites the timing registers between phases and checks
// every result field by field against a behavioral predictor or a known row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module one_wire_bus_master_top_tb;

  localparam int CW          = owm_pkg::CFG_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS    = 21;
  localparam int TIGHT_ROW   = 3;
  localparam int HOLD_CYCLES = 80;
  localparam int RUN_ITEMS   = 140;
  localparam logic [owm_pkg::CFG_W-1:0] TIME_MAX = 10'd1023;

  // spare op codes, executed as plain ticks
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_RST_TAIL, SEQ_SLOT
  } seq_phase_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       line_level;
    logic       known;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic [1:0] reset_status;
  } dir_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  owm_pkg::owm_in_t in_data;
  logic out_valid;
  logic out_ready;
  owm_pkg::owm_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [owm_pkg::CFG_W-1:0] cfg_data;

  // predictor state
  seq_phase_t m_phase;
  logic [9:0] m_ticks;
  logic [3:0] m_bits;
  logic [7:0] m_shift;
  logic       m_first;
  logic [1:0] m_status;
  logic [2:0] m_cmd;
  logic [7:0] m_last_read;
  logic [owm_pkg::CFG_W-1:0] timing_reg [8];
  logic [owm_pkg::CFG_W-1:0] timing_plan [8];

  owm_pkg::owm_out_t results_due[$];
  int errors = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;

  // directed items; expected result typed only on rows marked known
  dir_row_t dir_table [DIR_ROWS] = '{
    '{owm_pkg::OP_TICK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{OP_SPARE_LO,       8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{OP_SPARE_HI,       8'hA5, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{owm_pkg::OP_RESET, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{owm_pkg::OP_TICK,  8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{owm_pkg::OP_TICK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, owm_pkg::ST_NONE},
    '{owm_pkg::OP_RESET, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{owm_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{owm_pkg::OP_TICK,  8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, owm_pkg::ST_PRESENT},
    '{owm_pkg::OP_RESET, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{owm_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{owm_pkg::OP_TICK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, owm_pkg::ST_SHORTED},
    '{owm_pkg::OP_WRITE_BIT, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{owm_pkg::OP_READ_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{owm_pkg::OP_WRITE_BIT, 8'hFE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{owm_pkg::OP_TICK,  8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{owm_pkg::OP_READ_BIT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{owm_pkg::OP_TICK,  8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'h01, owm_pkg::ST_SHORTED},
    '{owm_pkg::OP_READ_BIT, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_PRESENT},
    '{OP_SPARE_HI,       8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, owm_pkg::ST_SHORTED},
    '{owm_pkg::OP_TICK,  8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, owm_pkg::ST_SHORTED}
  };

  one_wire_bus_master_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned at_least(input logic [owm_pkg::CFG_W-1:0] v,
                                           input int unsigned floor_v);
    return (32'(v) < floor_v) ? floor_v : 32'(v);
  endfunction

  // one bus tick of the master: returns the result item for this input item
  function automatic owm_pkg::owm_out_t advance_master(input owm_pkg::owm_in_t it);
    owm_pkg::owm_out_t r;
    int unsigned slot;
    int unsigned spos;
    int unsigned low;
    int unsigned nbits;
    logic rd;
    r = '0;
    if (m_phase == SEQ_IDLE && it.op >= owm_pkg::OP_RESET &&
        it.op <= owm_pkg::OP_READ_BYTE) begin
      m_cmd = it.op;
      m_ticks = '0;
      m_bits = '0;
      if (it.op == owm_pkg::OP_RESET) begin
        m_phase = SEQ_RST_LOW;
        m_shift = '0;
      end else begin
        m_phase = SEQ_SLOT;
        m_shift = (it.op == owm_pkg::OP_WRITE_BIT) ? {7'd0, it.data[0]} :
                  (it.op == owm_pkg::OP_WRITE_BYTE) ? it.data : 8'h00;
      end
    end
    r.busy_res = (m_phase != SEQ_IDLE);
    case (m_phase)
      SEQ_RST_LOW: begin
        r.drive_low = 1'b1;
        if (32'(m_ticks) + 1 >= at_least(timing_reg[owm_pkg::REG_RESET_LOW], 1)) begin
          m_phase = SEQ_RST_WAIT;
          m_ticks = '0;
        end else m_ticks = m_ticks + 1'b1;
      end
      SEQ_RST_WAIT: begin
        if (32'(m_ticks) + 1 >= at_least(timing_reg[owm_pkg::REG_PRESENCE_SAMP], 1)) begin
          m_first = it.line_level;
          m_phase = SEQ_RST_TAIL;
          m_ticks = '0;
        end else m_ticks = m_ticks + 1'b1;
      end
      SEQ_RST_TAIL: begin
        if (32'(m_ticks) + 1 >= at_least(timing_reg[owm_pkg::REG_RESET_TAIL], 1)) begin
          if (m_first) m_status = owm_pkg::ST_NONE;
          else m_status = it.line_level ? owm_pkg::ST_PRESENT : owm_pkg::ST_SHORTED;
          r.done_res = 1'b1;
          m_phase = SEQ_IDLE;
          m_ticks = '0;
        end else m_ticks = m_ticks + 1'b1;
      end
      SEQ_SLOT: begin
        slot = at_least(timing_reg[owm_pkg::REG_SLOT], 2);
        rd = (m_cmd == owm_pkg::OP_READ_BIT || m_cmd == owm_pkg::OP_READ_BYTE);
        nbits = (m_cmd == owm_pkg::OP_WRITE_BIT || m_cmd == owm_pkg::OP_READ_BIT) ? 1 : 8;
        if (rd) begin
          // a sample point past the slot end falls on the last slot tick
          spos = 32'(timing_reg[owm_pkg::REG_READ_SAMPLE]);
          if (spos > slot - 1) spos = slot - 1;
          r.drive_low = (m_ticks < timing_reg[owm_pkg::REG_READ_LOW]) || (m_ticks == '0);
          if (32'(m_ticks) == spos) m_shift = {it.line_level, m_shift[7:1]};
        end else begin
          low = m_shift[0] ? 32'(timing_reg[owm_pkg::REG_ONE_LOW]) :
                             32'(timing_reg[owm_pkg::REG_ZERO_LOW]);
          r.drive_low = (32'(m_ticks) < low) || (m_ticks == '0);
        end
        if (32'(m_ticks) + 1 >= slot) begin
          m_ticks = '0;
          if (!rd) m_shift = m_shift >> 1;
          m_bits = m_bits + 1'b1;
          if (32'(m_bits) >= nbits) begin
            if (rd) m_last_read = (nbits == 1) ? {7'd0, m_shift[7]} : m_shift;
            r.done_res = 1'b1;
            m_phase = SEQ_IDLE;
          end
        end else m_ticks = m_ticks + 1'b1;
      end
      default: ;
    endcase
    r.read_value = m_last_read;
    r.reset_status = m_status;
    return r;
  endfunction

  task automatic send_item(input owm_pkg::owm_in_t it, input logic known,
                           input owm_pkg::owm_out_t want);
    owm_pkg::owm_out_t pred;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (!in_ready);
    pred = advance_master(it);
    results_due.push_back(known ? want : pred);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // run out the current command on plain ticks, then let all results arrive
  task automatic quiesce();
    owm_pkg::owm_in_t it;
    while (m_phase != SEQ_IDLE) begin
      it.op = 3'($urandom_range(0, 7));
      it.data = 8'($urandom_range(0, 255));
      it.line_level = 1'($urandom_range(0, 1));
      send_item(it, 1'b0, '0);
    end
    drain();
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_timing();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_valid = 1'b1;
      cfg_index = i[owm_pkg::CFG_IDX_W-1:0];
      cfg_data = timing_plan[i];
      do @(posedge clk); while (!cfg_ready);
      timing_reg[i] = timing_plan[i];
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic plan_random(input int unsigned hi_time, input int unsigned hi_slot);
    for (int i = 0; i < 8; i++) timing_plan[i] = CW'($urandom_range(0, hi_time));
    timing_plan[owm_pkg::REG_SLOT] = CW'($urandom_range(0, hi_slot));
  endtask

  // mostly well-formed commands with random content; ops sent while busy
  // are ignored by the master and only advance the sequence timing
  task automatic run_random(input int count, input logic with_hold);
    owm_pkg::owm_in_t it;
    int roll;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == 10) holds_asked++;
      if (i == count / 2) drain();
      roll = $urandom_range(99);
      if (m_phase != SEQ_IDLE) it.op = 3'($urandom_range(0, 7));
      else if (roll < 88)
        it.op = 3'($urandom_range(owm_pkg::OP_RESET, owm_pkg::OP_READ_BYTE));
      else if (roll < 92) it.op = owm_pkg::OP_TICK;
      else if (roll < 96) it.op = OP_SPARE_LO;
      else it.op = OP_SPARE_HI;
      it.data = 8'($urandom_range(0, 255));
      it.line_level = 1'($urandom_range(0, 1));
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic flag_field(input string field, input logic [7:0] want_v,
                            input logic [7:0] got_v);
    errors++;
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want_v, got_v);
  endtask

  always @(posedge clk) begin : result_check
    owm_pkg::owm_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item, expected none actual %p", $time, out_data);
      end else begin
        want = results_due.pop_front();
        if (out_data.drive_low !== want.drive_low)
          flag_field("drive_low", 8'(want.drive_low), 8'(out_data.drive_low));
        if (out_data.busy_res !== want.busy_res)
          flag_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
        if (out_data.done_res !== want.done_res)
          flag_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
        if (out_data.read_value !== want.read_value)
          flag_field("read_value", want.read_value, out_data.read_value);
        if (out_data.reset_status !== want.reset_status)
          flag_field("reset_status", 8'(want.reset_status), 8'(out_data.reset_status));
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    owm_pkg::owm_in_t it;
    owm_pkg::owm_out_t want;
    logic [2:0] slow_ops [2];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    m_phase = SEQ_IDLE;
    m_ticks = '0;
    m_bits = '0;
    m_shift = '0;
    m_first = 1'b0;
    m_status = owm_pkg::ST_PRESENT;
    m_cmd = owm_pkg::OP_TICK;
    m_last_read = '0;
    timing_reg[owm_pkg::REG_RESET_LOW] = owm_pkg::RST_RESET_LOW;
    timing_reg[owm_pkg::REG_PRESENCE_SAMP] = owm_pkg::RST_PRESENCE_SAMP;
    timing_reg[owm_pkg::REG_RESET_TAIL] = owm_pkg::RST_RESET_TAIL;
    timing_reg[owm_pkg::REG_ONE_LOW] = owm_pkg::RST_ONE_LOW;
    timing_reg[owm_pkg::REG_ZERO_LOW] = owm_pkg::RST_ZERO_LOW;
    timing_reg[owm_pkg::REG_SLOT] = owm_pkg::RST_SLOT;
    timing_reg[owm_pkg::REG_READ_LOW] = owm_pkg::RST_READ_LOW;
    timing_reg[owm_pkg::REG_READ_SAMPLE] = owm_pkg::RST_READ_SAMPLE;
    slow_ops[0] = owm_pkg::OP_WRITE_BIT;
    slow_ops[1] = owm_pkg::OP_READ_BIT;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle ticks at reset timing, then minimal timing (max zero-low/sample)
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (r == TIGHT_ROW) begin
        quiesce();
        timing_plan[owm_pkg::REG_RESET_LOW] = '0;
        timing_plan[owm_pkg::REG_PRESENCE_SAMP] = '0;
        timing_plan[owm_pkg::REG_RESET_TAIL] = '0;
        timing_plan[owm_pkg::REG_ONE_LOW] = '0;
        timing_plan[owm_pkg::REG_ZERO_LOW] = TIME_MAX;
        timing_plan[owm_pkg::REG_SLOT] = '0;
        timing_plan[owm_pkg::REG_READ_LOW] = '0;
        timing_plan[owm_pkg::REG_READ_SAMPLE] = TIME_MAX;
        apply_timing();
      end
      it = '{dir_table[r].op, dir_table[r].data, dir_table[r].line_level};
      want = '{dir_table[r].drive_low, dir_table[r].busy_res, dir_table[r].done_res,
               dir_table[r].read_value, dir_table[r].reset_status};
      send_item(it, dir_table[r].known, want);
    end

    // random phases over a spread of timings and pacing
    quiesce();
    plan_random(6, 8);
    apply_timing();
    run_random(RUN_ITEMS, 1'b0);

    quiesce();
    idle_pct = 62;
    plan_random(4, 0);
    timing_plan[owm_pkg::REG_SLOT] = CW'($urandom_range(2, 5));
    timing_plan[owm_pkg::REG_ONE_LOW] = TIME_MAX;
    timing_plan[owm_pkg::REG_ZERO_LOW] = TIME_MAX;
    timing_plan[owm_pkg::REG_READ_LOW] = TIME_MAX;
    timing_plan[owm_pkg::REG_READ_SAMPLE] = TIME_MAX;
    apply_timing();
    run_random(RUN_ITEMS, 1'b0);

    quiesce();
    idle_pct = 0;
    stall_pct = 62;
    plan_random(6, 8);
    apply_timing();
    run_random(RUN_ITEMS, 1'b1);

    quiesce();
    idle_pct = 33;
    stall_pct = 33;
    for (int i = 0; i < 8; i++) timing_plan[i] = '0;
    apply_timing();
    run_random(RUN_ITEMS, 1'b0);

    quiesce();
    case ($urandom_range(0, 3))
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 62; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 62; end
      default: begin idle_pct = 33; stall_pct = 33; end
    endcase
    plan_random(12, 20);
    apply_timing();
    run_random(RUN_ITEMS, 1'b1);

    quiesce();
    idle_pct = 0;
    stall_pct = 0;
    plan_random(10, 10);
    apply_timing();
    run_random(RUN_ITEMS, 1'b0);

    // a bit write and a bit read at reset timing
    quiesce();
    timing_plan[owm_pkg::REG_RESET_LOW] = owm_pkg::RST_RESET_LOW;
    timing_plan[owm_pkg::REG_PRESENCE_SAMP] = owm_pkg::RST_PRESENCE_SAMP;
    timing_plan[owm_pkg::REG_RESET_TAIL] = owm_pkg::RST_RESET_TAIL;
    timing_plan[owm_pkg::REG_ONE_LOW] = owm_pkg::RST_ONE_LOW;
    timing_plan[owm_pkg::REG_ZERO_LOW] = owm_pkg::RST_ZERO_LOW;
    timing_plan[owm_pkg::REG_SLOT] = owm_pkg::RST_SLOT;
    timing_plan[owm_pkg::REG_READ_LOW] = owm_pkg::RST_READ_LOW;
    timing_plan[owm_pkg::REG_READ_SAMPLE] = owm_pkg::RST_READ_SAMPLE;
    apply_timing();
    for (int k = 0; k < 2; k++) begin
      it.op = slow_ops[k];
      it.data = 8'($urandom_range(0, 255));
      it.line_level = 1'($urandom_range(0, 1));
      send_item(it, 1'b0, '0);
      quiesce();
    end

    quiesce();
    repeat (4) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
sv/owm_pkg.sv
sv/owm_cfg.sv
sv/owm_core.sv
sv/one_wire_bus_master_top.sv
verif/one_wire_bus_master_top_tb.sv
